### src/assert_macros.svh
// Assertion macros shared by the RTL of the volume/pan ramp unit.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### src/msvpr_pkg.sv
// Types, constants and the slew helper of the volume/pan ramp unit.
// No dependencies.
package msvpr_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int SLOT_W    = 3;
    localparam int BYTE_W    = 8;
    localparam int FLAG_W    = 24;
    localparam int FUNC_W    = 2;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 56;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

    localparam logic [FUNC_W-1:0] FUNC_TICK      = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WR_MODE   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_WR_VOLPAN = 2'd2;

    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_MUTE   = 1'b1;

    localparam logic [BYTE_W-1:0] MODE_CENTER = 8'd0;
    localparam logic [BYTE_W-1:0] MODE_LEFT   = 8'd1;
    localparam logic [BYTE_W-1:0] MODE_RIGHT  = 8'd2;
    localparam logic [BYTE_W-1:0] MODE_GONE   = 8'd3;

    localparam logic [BYTE_W-1:0] VOL_CENTER = 8'hFF;
    localparam logic [BYTE_W-1:0] PAN_CENTER = 8'h80;
    localparam logic [BYTE_W-1:0] VOL_SIDE   = 8'h64;
    localparam logic [BYTE_W-1:0] PAN_LEFT   = 8'h3C;
    localparam logic [BYTE_W-1:0] PAN_RIGHT  = 8'hC3;
    localparam logic [BYTE_W-1:0] VOL_GONE   = 8'h00;
    localparam logic [BYTE_W-1:0] VOL_STEP   = 8'd8;
    localparam logic [BYTE_W-1:0] PAN_STEP   = 8'd2;
    localparam logic [BYTE_W-1:0] PAN_RESET  = 8'h80;
    localparam logic [BYTE_W-1:0] FLAG_MID   = 8'h80;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SLOT,
        ST_MUTE,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic              kind;
        logic [SLOT_W-1:0] slot_index;
        logic [BYTE_W-1:0] sound_id;
        logic [BYTE_W-1:0] level;
        logic [BYTE_W-1:0] balance;
        logic [FLAG_W-1:0] flag_word;
    } t_result;

    // Step cur toward tgt by step, landing on tgt when at most one step away.
    function automatic logic [BYTE_W-1:0] slew(input logic [BYTE_W-1:0] cur,
                                               input logic [BYTE_W-1:0] tgt,
                                               input logic [BYTE_W-1:0] step);
        logic [BYTE_W-1:0] res;
        res = cur;
        if (cur < tgt) begin
            res = ((tgt - cur) <= step) ? tgt : cur + step;
        end else if (cur > tgt) begin
            res = ((cur - tgt) <= step) ? tgt : cur - step;
        end
        return res;
    endfunction

endpackage

### src/multi_slot_volume_pan_ramp_unit.sv
// Eight-slot volume/pan slew ramp generator with a stream in and a stream out.
// Depends on msvpr_pkg and assert_macros.svh.
//
// Usage:
//   Input stream (s_axis): tuser carries the function (tick, write mode, write
//   volume and pan), tdata the slot and the values. Write items leave the input ready.
//   A tick walks the slots through one shared slew unit, one slot per cycle while
//   the output keeps up, with a mute step after each slot that settles into gone
//   mode and a closing flush step; the input is not ready until the tick is done.
//   Output stream (m_axis): one transfer per result. Each result is held in a
//   pending register until the next one is known, so tlast can mark the final
//   result of the tick; a result moves to the output register in the cycle the
//   next result of the tick is produced, the final one in the closing flush step.
//   A stalled receiver holds the output register; the slot walk stops only when
//   both the pending and the output register are full.
//   Configuration: i_cfg_we writes the sound id of slot i_cfg_addr.
//   Reset (synchronous, active low) sets every mode to center, every volume to
//   zero, every pan to mid, every sound id to zero and empties the output.
`include "assert_macros.svh"

module multi_slot_volume_pan_ramp_unit
    import msvpr_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // slave side
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [IN_DATA_W-1:0]    s_axis_tdata,   // slot, mode_value, volume_value, pan_value
    input  logic [FUNC_W-1:0]       s_axis_tuser,   // func
    // master side
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_DATA_W-1:0]   m_axis_tdata,   // slot_index, sound_id, level, balance,
                                                    // flag_word
    output logic [0:0]              m_axis_tuser,   // kind
    output logic                    m_axis_tlast,   // last
    // configuration
    input  logic                    i_cfg_we,
    input  logic [SLOT_W-1:0]       i_cfg_addr,
    input  logic [BYTE_W-1:0]       i_cfg_wdata
);

    t_state              r_state, n_state;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [BYTE_W-1:0]   r_mode [NUM_SLOTS];
    logic [BYTE_W-1:0]   n_mode [NUM_SLOTS];
    logic [BYTE_W-1:0]   r_prev [NUM_SLOTS];
    logic [BYTE_W-1:0]   n_prev [NUM_SLOTS];
    logic [BYTE_W-1:0]   r_vol  [NUM_SLOTS];
    logic [BYTE_W-1:0]   n_vol  [NUM_SLOTS];
    logic [BYTE_W-1:0]   r_pan  [NUM_SLOTS];
    logic [BYTE_W-1:0]   n_pan  [NUM_SLOTS];
    logic [BYTE_W-1:0]   r_sid  [NUM_SLOTS];

    logic                r_pend_valid, n_pend_valid;
    t_result             r_pend, n_pend;
    logic                r_out_valid, n_out_valid;
    t_result             r_out, n_out;
    logic                r_out_last, n_out_last;

    logic [SLOT_W-1:0]   in_slot;
    logic [BYTE_W-1:0]   in_mode, in_vol, in_pan;
    logic                in_slot_ok;
    logic                in_fire;

    logic [BYTE_W-1:0]   cur_mode, cur_vol, cur_pan, cur_sid;
    logic [BYTE_W-1:0]   tgt_vol, tgt_pan, new_vol, new_pan;
    logic                on_target, settled, has_update;
    logic                out_free, can_emit;
    t_result             upd_res, mute_res;

    assign in_slot    = s_axis_tdata[SLOT_W-1:0];
    assign in_mode    = s_axis_tdata[SLOT_W+BYTE_W-1:SLOT_W];
    assign in_vol     = s_axis_tdata[SLOT_W+2*BYTE_W-1:SLOT_W+BYTE_W];
    assign in_pan     = s_axis_tdata[SLOT_W+3*BYTE_W-1:SLOT_W+2*BYTE_W];
    assign in_slot_ok = ({1'b0, in_slot} < (SLOT_W+1)'(NUM_SLOTS));

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {(OUT_DATA_W-SLOT_W-3*BYTE_W-FLAG_W)'(0), r_out.flag_word,
                            r_out.balance, r_out.level, r_out.sound_id, r_out.slot_index};

    // Shared slew unit, fed by the slot under the walk pointer.
    assign cur_mode = r_mode[r_slot];
    assign cur_vol  = r_vol[r_slot];
    assign cur_pan  = r_pan[r_slot];
    assign cur_sid  = r_sid[r_slot];

    always_comb begin
        unique case (cur_mode)
            MODE_CENTER: begin
                tgt_vol = VOL_CENTER;
                tgt_pan = PAN_CENTER;
            end
            MODE_LEFT: begin
                tgt_vol = VOL_SIDE;
                tgt_pan = PAN_LEFT;
            end
            MODE_RIGHT: begin
                tgt_vol = VOL_SIDE;
                tgt_pan = PAN_RIGHT;
            end
            default: begin
                tgt_vol = VOL_GONE;
                tgt_pan = cur_pan;
            end
        endcase
    end

    assign new_vol    = slew(cur_vol, tgt_vol, VOL_STEP);
    assign new_pan    = slew(cur_pan, tgt_pan, PAN_STEP);
    assign on_target  = (cur_vol == tgt_vol) && (cur_pan == tgt_pan);
    assign settled    = (new_vol == tgt_vol) && (new_pan == tgt_pan);
    assign has_update = (cur_sid != '0);

    assign out_free = !r_out_valid || m_axis_tready;
    assign can_emit = !r_pend_valid || out_free;

    always_comb begin
        upd_res.kind       = KIND_UPDATE;
        upd_res.slot_index = r_slot;
        upd_res.sound_id   = cur_sid;
        upd_res.level      = new_vol;
        upd_res.balance    = new_pan;
        upd_res.flag_word  = {new_vol, FLAG_MID, new_pan};

        mute_res.kind       = KIND_MUTE;
        mute_res.slot_index = r_slot;
        mute_res.sound_id   = cur_sid;
        mute_res.level      = cur_vol;
        mute_res.balance    = cur_pan;
        mute_res.flag_word  = '0;
    end

    always_comb begin
        n_state      = r_state;
        n_slot       = r_slot;
        n_mode       = r_mode;
        n_prev       = r_prev;
        n_vol        = r_vol;
        n_pan        = r_pan;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out        = r_out;
        n_out_last   = r_out_last;

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    unique case (s_axis_tuser)
                        FUNC_TICK: begin
                            n_state = ST_SLOT;
                            n_slot  = '0;
                        end
                        FUNC_WR_MODE: begin
                            if (in_slot_ok) begin
                                n_mode[in_slot] = in_mode;
                            end
                        end
                        FUNC_WR_VOLPAN: begin
                            if (in_slot_ok) begin
                                n_vol[in_slot] = in_vol;
                                n_pan[in_slot] = in_pan;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SLOT: begin
                // Hold the slot while an update has nowhere to go.
                if (!(!on_target && has_update && !can_emit)) begin
                    if (!on_target) begin
                        n_vol[r_slot] = new_vol;
                        n_pan[r_slot] = new_pan;
                        if (has_update) begin
                            if (r_pend_valid) begin
                                n_out_valid = 1'b1;
                                n_out       = r_pend;
                                n_out_last  = 1'b0;
                            end
                            n_pend_valid = 1'b1;
                            n_pend       = upd_res;
                        end
                        if (settled) begin
                            n_prev[r_slot] = cur_mode;
                        end
                    end
                    if (!on_target && settled && cur_mode == MODE_GONE) begin
                        n_state = ST_MUTE;
                    end else if (r_slot == LAST_SLOT) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_slot = r_slot + 1'b1;
                    end
                end
            end
            ST_MUTE: begin
                if (can_emit) begin
                    if (r_pend_valid) begin
                        n_out_valid = 1'b1;
                        n_out       = r_pend;
                        n_out_last  = 1'b0;
                    end
                    n_pend_valid = 1'b1;
                    n_pend       = mute_res;
                    if (r_slot == LAST_SLOT) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_state = ST_SLOT;
                        n_slot  = r_slot + 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                // Release the final result of the tick with last set.
                if (!r_pend_valid) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out        = r_pend;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_slot       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_last   <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_mode[i] <= MODE_CENTER;
                r_prev[i] <= MODE_CENTER;
                r_vol[i]  <= '0;
                r_pan[i]  <= PAN_RESET;
                r_sid[i]  <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_slot       <= n_slot;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            r_out_last   <= n_out_last;
            r_mode       <= n_mode;
            r_prev       <= n_prev;
            r_vol        <= n_vol;
            r_pan        <= n_pan;
            if (i_cfg_we && ({1'b0, i_cfg_addr} < (SLOT_W+1)'(NUM_SLOTS))) begin
                r_sid[i_cfg_addr] <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    `ASSERT_IMPL(a_idle_no_pending, i_clk, i_rst_n, r_state == ST_IDLE, !r_pend_valid)
    `ASSERT_IMPL(a_mute_only_gone, i_clk, i_rst_n, r_state == ST_MUTE,
                 r_mode[r_slot] == MODE_GONE && r_prev[r_slot] == MODE_GONE)
    `ASSERT_IMPL(a_flush_at_last, i_clk, i_rst_n, r_state == ST_FLUSH, r_slot == LAST_SLOT)
    `ASSERT_NEXT(a_tick_starts_walk, i_clk, i_rst_n,
                 in_fire && s_axis_tuser == FUNC_TICK, r_state == ST_SLOT && r_slot == '0)

endmodule
